### rtl/core/tpr_pkg.sv
// Package with payload types and constants for the two-pole resonator.
`timescale 1ns / 1ps

package tpr_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int COEF_BITS   = 24;
    localparam int RATE_BITS   = 18;
    localparam int CFG_BITS    = 24;
    localparam int CFG_IDX_BITS = 3;

    // pi with 40 fraction bits, split in two halves for narrow multipliers
    localparam int          PI_BITS  = 42;
    localparam int          PI_SPLIT = 21;
    localparam logic [PI_BITS-1:0] PI_Q40 = 42'h3243F6A8886;
    localparam logic [PI_SPLIT-1:0] PI_HI = PI_Q40[PI_BITS-1:PI_SPLIT];
    localparam logic [PI_SPLIT-1:0] PI_LO = PI_Q40[PI_SPLIT-1:0];

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_INPUT_GAIN   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_FEEDBACK_ONE = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_FEEDBACK_TWO = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_SAMPLE_RATE  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_CENTRE_FREQ  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_BANDWIDTH    = 3'd5;

    localparam logic [RATE_BITS-1:0] SAMPLE_RATE_RESET = 18'd48000;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic                          end_of_block;
    } tpr_in_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic                          saturated;
        logic                          block_end;
    } tpr_out_t;

    // one scaled and clipped product
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] value;
        logic                          sat;
    } tpr_prod_t;

endpackage

### rtl/core/two_pole_resonator_top.sv
// Two-pole resonator: y = gain*x + fb1*y[n-1] - fb2*y[n-2], saturating, with bypass.
//
// Usage:
//   Input samples arrive on in_valid/in_ready with an in_data struct; one
//   filtered sample leaves on out_valid/out_ready per input transaction.
//   Coefficients and the bypass frequencies are written through cfg_we,
//   cfg_index and cfg_data; writes take effect at once, but a bandwidth write
//   passes through the registered bandwidth*pi products first. Writes are only
//   to be made by the user while no sample is in flight; the block does not
//   enforce it. An accepted sample sits in the input register while the three
//   products, the sum and the history update settle into the output register.
//   Throughput is one sample per cycle while out_ready is high; the loop through
//   the history registers, three multipliers and the saturating adder sets it.
//   When out_ready is low the output register holds its sample and the
//   input register keeps one more; in_ready drops once both are full.
//   Reset clears the history, coefficients, frequencies and bandwidth,
//   sets the sample rate to 48000 and empties both pipeline registers.
`timescale 1ns / 1ps

module two_pole_resonator_top
    import tpr_pkg::*;
#(
    parameter int COEF_FRAC_BITS = 21
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  tpr_in_t                 in_data,
    output logic                    out_valid,
    input  logic                    out_ready,
    output tpr_out_t                out_data,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]     cfg_data
);

    localparam int PROD_BITS = COEF_BITS + SAMPLE_BITS;
    localparam int SUM_BITS  = SAMPLE_BITS + 2;
    localparam int BWP_BITS  = RATE_BITS + PI_SPLIT;
    localparam int CMP_BITS  = RATE_BITS + PI_BITS + 1;

    localparam logic signed [PROD_BITS-1:0] ROUND_HALF =
        PROD_BITS'(64'd1 << (COEF_FRAC_BITS - 1));
    localparam logic signed [PROD_BITS-1:0] PROD_MAX =
        {{(PROD_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [PROD_BITS-1:0] PROD_MIN = ~PROD_MAX;
    localparam logic signed [SUM_BITS-1:0] SUM_MAX =
        {{(SUM_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SUM_BITS-1:0] SUM_MIN = ~SUM_MAX;

    // rounded (ties up), shifted and clipped coefficient product
    function automatic tpr_prod_t scale_product(
        input logic signed [COEF_BITS-1:0]   coef,
        input logic signed [SAMPLE_BITS-1:0] x
    );
        logic signed [PROD_BITS-1:0] p;
        logic signed [PROD_BITS-1:0] q;
        tpr_prod_t                   r;
        p = PROD_BITS'(coef) * PROD_BITS'(x);
        q = (p + ROUND_HALF) >>> COEF_FRAC_BITS;
        r.sat = 1'b1;
        if (q > PROD_MAX)
        begin
            r.value = PROD_MAX[SAMPLE_BITS-1:0];
        end
        else if (q < PROD_MIN)
        begin
            r.value = PROD_MIN[SAMPLE_BITS-1:0];
        end
        else
        begin
            r.value = q[SAMPLE_BITS-1:0];
            r.sat   = 1'b0;
        end
        return r;
    endfunction

    // configuration registers
    logic signed [COEF_BITS-1:0] input_gain_reg;
    logic signed [COEF_BITS-1:0] feedback_one_reg;
    logic signed [COEF_BITS-1:0] feedback_two_reg;
    logic [RATE_BITS-1:0]        sample_rate_reg;
    logic [RATE_BITS-1:0]        centre_freq_reg;
    logic [RATE_BITS-1:0]        bandwidth_reg;

    // bandwidth*pi partial products, registered from bandwidth_reg
    logic [BWP_BITS-1:0] bw_pi_hi_reg;
    logic [BWP_BITS-1:0] bw_pi_lo_reg;

    // history
    logic signed [SAMPLE_BITS-1:0] prev_out1_reg;
    logic signed [SAMPLE_BITS-1:0] prev_out2_reg;

    // pipeline
    logic     in_valid_reg;
    tpr_in_t  in_data_reg;
    logic     out_valid_reg;
    tpr_out_t out_data_reg;

    logic      advance;
    logic      fire;
    logic      active;
    logic [CMP_BITS-1:0] bw_pi;
    logic [CMP_BITS-1:0] rate_limit;
    tpr_prod_t prod_a;
    tpr_prod_t prod_b;
    tpr_prod_t prod_c;
    logic signed [SUM_BITS-1:0] sum;
    tpr_out_t  result;

    assign advance   = !out_valid_reg || out_ready;
    assign fire      = in_valid_reg && advance;
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            input_gain_reg   <= '0;
            feedback_one_reg <= '0;
            feedback_two_reg <= '0;
            sample_rate_reg  <= SAMPLE_RATE_RESET;
            centre_freq_reg  <= '0;
            bandwidth_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_INPUT_GAIN:   input_gain_reg   <= cfg_data[COEF_BITS-1:0];
                REG_FEEDBACK_ONE: feedback_one_reg <= cfg_data[COEF_BITS-1:0];
                REG_FEEDBACK_TWO: feedback_two_reg <= cfg_data[COEF_BITS-1:0];
                REG_SAMPLE_RATE:  sample_rate_reg  <= cfg_data[RATE_BITS-1:0];
                REG_CENTRE_FREQ:  centre_freq_reg  <= cfg_data[RATE_BITS-1:0];
                REG_BANDWIDTH:    bandwidth_reg    <= cfg_data[RATE_BITS-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bw_pi_hi_reg <= '0;
            bw_pi_lo_reg <= '0;
        end
        else
        begin
            bw_pi_hi_reg <= BWP_BITS'(bandwidth_reg) * BWP_BITS'(PI_HI);
            bw_pi_lo_reg <= BWP_BITS'(bandwidth_reg) * BWP_BITS'(PI_LO);
        end
    end

    // bandwidth*pi < 2*rate, and 0 < centre < rate/2
    always_comb
    begin
        bw_pi      = (CMP_BITS'(bw_pi_hi_reg) << PI_SPLIT) + CMP_BITS'(bw_pi_lo_reg);
        rate_limit = CMP_BITS'(sample_rate_reg) << (PI_BITS - 1);
        active     = (bw_pi < rate_limit)
                     && (centre_freq_reg != '0)
                     && (centre_freq_reg < (sample_rate_reg >> 1));
    end

    always_comb
    begin
        prod_a = scale_product(input_gain_reg, in_data_reg.sample_in);
        prod_b = scale_product(feedback_one_reg, prev_out1_reg);
        prod_c = scale_product(feedback_two_reg, prev_out2_reg);
        sum    = SUM_BITS'(prod_a.value) + SUM_BITS'(prod_b.value)
                 - SUM_BITS'(prod_c.value);
        result.block_end = in_data_reg.end_of_block;
        if (!active)
        begin
            result.sample_out = in_data_reg.sample_in;
            result.saturated  = 1'b0;
        end
        else
        begin
            result.saturated = prod_a.sat || prod_b.sat || prod_c.sat;
            if (sum > SUM_MAX)
            begin
                result.sample_out = SUM_MAX[SAMPLE_BITS-1:0];
                result.saturated  = 1'b1;
            end
            else if (sum < SUM_MIN)
            begin
                result.sample_out = SUM_MIN[SAMPLE_BITS-1:0];
                result.saturated  = 1'b1;
            end
            else
            begin
                result.sample_out = sum[SAMPLE_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_out1_reg <= '0;
            prev_out2_reg <= '0;
        end
        else if (fire && active)
        begin
            prev_out1_reg <= result.sample_out;
            prev_out2_reg <= prev_out1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_data_reg <= in_data;
        end
        if (fire)
        begin
            out_data_reg <= result;
        end
    end

endmodule
